// ===== design/mef_pkg.sv =====
// ----------------------------------------------------------------------------
// Majority element finder package
// Shared sizes, the controller state type and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mef_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  // One more bit than the address so that a count can hold MAX_ITEMS itself.
  localparam int CNT_W     = ADDR_W + 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;   // an element is accepted this cycle
    logic scan;   // the verification pass is running
    logic clear;  // the result is taken; start a new sequence
  } cmd_t;

  typedef struct packed {
    logic scan_done;  // every stored element has been compared
  } status_t;

endpackage

// ===== design/mef_if.sv =====
// ----------------------------------------------------------------------------
// Majority element finder channels
// Valid/ready channels for incoming elements and for the result item.
// ----------------------------------------------------------------------------
interface mef_in_if;
  import mef_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface mef_out_if;
  import mef_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] majority_value;

  modport source (output valid, output found, output majority_value, input ready);
  modport sink   (input valid, input found, input majority_value, output ready);
endinterface

// ===== design/mef_ctrl.sv =====
// ----------------------------------------------------------------------------
// Majority element finder controller
// Sequences loading, the verification pass and the result handshake.
// ----------------------------------------------------------------------------
module mef_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mef_pkg::cmd_t    cmd,
  input  mef_pkg::status_t status
);
  import mef_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_ready) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/mef_datapath.sv =====
// ----------------------------------------------------------------------------
// Majority element finder datapath
// Element store, vote registers, verification counter and result logic.
// ----------------------------------------------------------------------------
module mef_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mef_pkg::cmd_t                     cmd,
  output mef_pkg::status_t                  status,
  input  logic signed [mef_pkg::DATA_W-1:0] value,
  output logic                              found,
  output logic signed [mef_pkg::DATA_W-1:0] majority_value
);
  import mef_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] vote_candidate;
  logic [CNT_W-1:0]         item_count;
  logic [CNT_W-1:0]         vote_tally;
  logic [CNT_W-1:0]         rd_idx;
  logic [CNT_W-1:0]         hits;
  logic                     rd_vld;
  logic                     room;
  logic                     issue;

  assign room  = (item_count != CNT_W'(MAX_ITEMS));
  assign issue = cmd.scan && (rd_idx != item_count);

  // Store write and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[item_count[ADDR_W-1:0]] <= value;
    end
    rd_data <= mem[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      item_count     <= '0;
      vote_tally     <= '0;
      vote_candidate <= '0;
      rd_idx         <= '0;
      rd_vld         <= 1'b0;
      hits           <= '0;
    end else begin
      if (cmd.load && room) begin
        item_count <= item_count + 1'b1;
        if (vote_tally == '0) begin
          vote_candidate <= value;
          vote_tally     <= CNT_W'(1);
        end else if (vote_candidate == value) begin
          vote_tally <= vote_tally + 1'b1;
        end else begin
          vote_tally <= vote_tally - 1'b1;
        end
      end
      rd_vld <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_vld && (rd_data == vote_candidate)) begin
        hits <= hits + 1'b1;
      end
    end
  end

  assign status.scan_done = cmd.scan && !rd_vld && (rd_idx == item_count);

  assign found          = (item_count != '0) && (hits > (item_count >> 1));
  assign majority_value = found ? vote_candidate : '0;

endmodule

// ===== design/majority_element_find.sv =====
// ----------------------------------------------------------------------------
// Majority element finder
// Finds the value that occurs in more than half of a sequence of elements.
// ----------------------------------------------------------------------------
// Elements arrive one per cycle on item_in; the element with last_item set
// closes the sequence. While loading, every element is written to a
// 1024-entry store and a Boyer-Moore vote keeps a candidate and a tally.
// Elements beyond the store's depth are dropped, but a dropped element that
// is marked last still closes the sequence. After the last element the
// controller runs a verification pass that reads the store through its single
// registered read port, one entry per cycle, and counts the candidate's
// occurrences. The result item then waits on result_out (found, and the
// value or zero) until it is taken; item_in is not ready from the last
// element until the result is taken, after which a new sequence starts
// with all counters cleared.
module majority_element_find (
  input logic      clk,
  input logic      rst,
  mef_in_if.sink   item_in,
  mef_out_if.source result_out
);
  import mef_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: owns the handshakes and issues commands to the datapath.
  mef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_last   (item_in.last_item),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: the store, the vote and the verification count. The result
  // fields come straight from its registers and so stay stable while the
  // result waits.
  mef_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .value          (item_in.value),
    .found          (result_out.found),
    .majority_value (result_out.majority_value)
  );

endmodule

// ===== design/mef_checker.sv =====
// ----------------------------------------------------------------------------
// Majority element finder checker
// Port-level assertions on the sequencing of elements and results.
// ----------------------------------------------------------------------------
module mef_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              found,
  input logic signed [mef_pkg::DATA_W-1:0] majority_value
);
  import mef_pkg::*;

  // No element is taken while a result waits.
  a_no_load_during_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("element accepted while a result is pending");

  // The last element closes the sequence: input stalls in the next cycle.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (!in_ready && !out_valid))
    else $error("input still open after the last element");

  // A missing majority reports zero.
  a_zero_when_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (majority_value == '0))
    else $error("nonzero value with no majority");

  // A taken result is delivered once.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

  // A stalled result holds its fields.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(found) && $stable(majority_value)))
    else $error("stalled result changed");

endmodule

bind majority_element_find mef_checker u_mef_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item_in.valid),
  .in_ready       (item_in.ready),
  .in_last        (item_in.last_item),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .found          (result_out.found),
  .majority_value (result_out.majority_value)
);
